// ===== design/fsvc_pkg.sv =====
// ----------------------------------------------------------------------------
// fsvc_pkg
// Shared types and constants for the first-seen value counter.
// ----------------------------------------------------------------------------
package fsvc_pkg;

  localparam int DEFAULT_DEPTH      = 64;
  localparam int DEFAULT_VALUE_BITS = 32;
  localparam int VALUE_W            = 32;
  localparam int COUNT_W            = 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CMP,
    S_NEW,
    S_ERD,
    S_ELD
  } state_t;

  typedef struct packed {
    logic load_in;
    logic clr_idx;
    logic inc_idx;
    logic rd_en;
    logic wr_inc;
    logic wr_new;
    logic set_ovf;
    logic emit_load;
    logic clr_table;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic match;
    logic full;
    logic fin;
    logic out_free;
    logic emit_end;
  } ctrl_stat_t;

endpackage

// ===== design/fsvc_ctrl.sv =====
// ----------------------------------------------------------------------------
// fsvc_ctrl
// Sequencer for table search, insert and result emission.
// ----------------------------------------------------------------------------
module fsvc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fsvc_pkg::ctrl_stat_t stat,
  output fsvc_pkg::ctrl_cmd_t  cmd
);
  import fsvc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          cmd.clr_idx = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_NEW;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (stat.match) begin
          cmd.wr_inc = 1'b1;
          if (stat.fin) begin
            cmd.clr_idx = 1'b1;
            state_next  = S_ERD;
          end else begin
            state_next = S_IDLE;
          end
        end else begin
          cmd.inc_idx = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_NEW: begin
        if (stat.full) begin
          cmd.set_ovf = 1'b1;
        end else begin
          cmd.wr_new = 1'b1;
        end
        if (stat.fin) begin
          cmd.clr_idx = 1'b1;
          state_next  = S_ERD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_ERD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_ELD;
      end
      S_ELD: begin
        if (stat.out_free) begin
          cmd.emit_load = 1'b1;
          cmd.inc_idx   = 1'b1;
          if (stat.emit_end) begin
            cmd.clr_table = 1'b1;
            state_next    = S_IDLE;
          end else begin
            state_next = S_ERD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/fsvc_datapath.sv =====
// ----------------------------------------------------------------------------
// fsvc_datapath
// Value and count tables, scan index, fill count and output register.
// ----------------------------------------------------------------------------
module fsvc_datapath #(
  parameter int TABLE_DEPTH = fsvc_pkg::DEFAULT_DEPTH,
  parameter int VALUE_BITS  = fsvc_pkg::DEFAULT_VALUE_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [fsvc_pkg::VALUE_W-1:0] value,
  input  logic                         last,
  input  fsvc_pkg::ctrl_cmd_t          cmd,
  output fsvc_pkg::ctrl_stat_t         stat,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [fsvc_pkg::COUNT_W-1:0] count,
  output logic                         last_res,
  output logic                         overflow
);
  import fsvc_pkg::*;

  localparam int USED_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [VALUE_BITS-1:0] vals [TABLE_DEPTH];
  logic [COUNT_W-1:0]    cnts [TABLE_DEPTH];

  logic [VALUE_BITS-1:0] key;
  logic                  fin;
  logic [USED_W-1:0]     used;
  logic [USED_W-1:0]     idx;
  logic                  ovf;
  logic [VALUE_BITS-1:0] rd_val;
  logic [COUNT_W-1:0]    rd_cnt;

  logic [63:0]           value_wide;
  logic [IDX_W-1:0]      wr_addr;
  logic [COUNT_W-1:0]    cnt_wdata;

  assign value_wide = 64'(value);
  assign wr_addr    = cmd.wr_new ? used[IDX_W-1:0] : idx[IDX_W-1:0];
  assign cnt_wdata  = cmd.wr_new ? COUNT_W'(1) :
                      ((rd_cnt == {COUNT_W{1'b1}}) ? rd_cnt : rd_cnt + COUNT_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      key <= value_wide[VALUE_BITS-1:0];
      fin <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_new) begin
      vals[wr_addr] <= key;
    end
    if (cmd.wr_new || cmd.wr_inc) begin
      cnts[wr_addr] <= cnt_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_val <= vals[idx[IDX_W-1:0]];
      rd_cnt <= cnts[idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      idx  <= '0;
      ovf  <= 1'b0;
    end else begin
      if (cmd.clr_idx) begin
        idx <= '0;
      end else if (cmd.inc_idx) begin
        idx <= idx + USED_W'(1);
      end
      if (cmd.clr_table) begin
        used <= '0;
        ovf  <= 1'b0;
      end else begin
        if (cmd.wr_new) begin
          used <= used + USED_W'(1);
        end
        if (cmd.set_ovf) begin
          ovf <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      count    <= rd_cnt;
      last_res <= stat.emit_end;
      overflow <= ovf;
    end
  end

  assign stat.scan_done = (idx == used);
  assign stat.match     = (rd_val == key);
  assign stat.full      = (used == USED_W'(TABLE_DEPTH));
  assign stat.fin       = fin;
  assign stat.out_free  = !out_valid || !out_stall;
  assign stat.emit_end  = (({1'b0, idx} + (USED_W + 1)'(1)) == {1'b0, used});

endmodule

// ===== design/first_seen_value_counter_top.sv =====
// ----------------------------------------------------------------------------
// first_seen_value_counter_top
// Counts occurrences of distinct values in first-appearance order.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+----------------------------
//  in      | in_valid / in_stall  | value, last
//  out     | out_valid / out_stall| count, last_res, overflow
//
//  A request reads the table entries one at a time through the single read port
//  of the tables, comparing each with the value until a match or the fill count.
//  A final request then emits one count per stored entry, pausing on out_stall.
//  Reset clears the fill count, the overflow flag and the output valid.
//  A waiting result is held in the output register while new requests proceed.
// ----------------------------------------------------------------------------
module first_seen_value_counter_top #(
  parameter int TABLE_DEPTH = fsvc_pkg::DEFAULT_DEPTH,
  parameter int VALUE_BITS  = fsvc_pkg::DEFAULT_VALUE_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [fsvc_pkg::VALUE_W-1:0] value,
  input  logic                         last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [fsvc_pkg::COUNT_W-1:0] count,
  output logic                         last_res,
  output logic                         overflow
);
  import fsvc_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  fsvc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  fsvc_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .last      (last),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .count     (count),
    .last_res  (last_res),
    .overflow  (overflow)
  );

endmodule
